// File: hdl/bmp3_pkg.sv
package bmp3_pkg;

  // Default frame size limits
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int MIN_SIZE     = 3;

  // Block geometry: position of a pixel inside its block, along x or y
  localparam int BLOCK = 3;
  localparam logic [1:0] BLK_FIRST = 2'd0;
  localparam logic [1:0] BLK_LAST  = 2'd2;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int TRIPLE_W = 10;
  localparam int SUM_W    = 12;
  localparam int IDX_W    = 10;
  localparam int MEAN_W   = 8;
  localparam int TDATA_W  = 32;

  // floor(x / 9) = (x * 3641) >> 15 for every 12-bit x
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int PROD_W     = 24;

  localparam int QUEUE_DEPTH = 4;

endpackage

// File: hdl/bmp3_ram.sv
module bmp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hdl/bmp3_fifo.sv
module bmp3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNTW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNTW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: hdl/bmp3_front.sv
module bmp3_front #(
  parameter int MAX_WIDTH  = bmp3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmp3_pkg::MAX_HEIGHT_DEF,
  localparam int BLK_DEPTH = MAX_WIDTH / bmp3_pkg::BLOCK,
  localparam int AW = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bmp3_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bmp3_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bmp3_pkg::PIX_W-1:0]          pixel_i,
  input  logic                                sof_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output logic [bmp3_pkg::TRIPLE_W-1:0]       item_triple_o,
  output logic [AW-1:0]                       item_bc_o,
  output logic [bmp3_pkg::IDX_W-1:0]          item_br_o,
  output logic [1:0]                          item_ry_o,
  output logic                                item_last_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int XW  = CW + 2;
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int YW  = RW + 2;
  localparam int LXW = (XW > bmp3_pkg::CFG_W) ? XW : bmp3_pkg::CFG_W;
  localparam int LYW = (YW > bmp3_pkg::CFG_W) ? YW : bmp3_pkg::CFG_W;
  localparam int W_RST = (bmp3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                             : bmp3_pkg::WIDTH_RESET;
  localparam int H_RST = (bmp3_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : bmp3_pkg::HEIGHT_RESET;

  logic [XW-1:0] width_q;
  logic [YW-1:0] height_q;
  logic [LXW-1:0] cfg_wx;
  logic [LYW-1:0] cfg_hx;
  logic [XW-1:0] width_clamped;
  logic [YW-1:0] height_clamped;

  logic [CW-1:0]  base_q;
  logic [1:0]     cx_q;
  logic [AW-1:0]  bc_q;
  logic [RW-1:0]  rbase_q;
  logic [1:0]     ry_q;
  logic [bmp3_pkg::IDX_W-1:0]    br_q;
  logic [bmp3_pkg::TRIPLE_W-1:0] triple_q;

  logic [XW-1:0]  base;
  logic [1:0]     cx;
  logic [AW-1:0]  bc;
  logic [YW-1:0]  rbase;
  logic [1:0]     ry;
  logic [bmp3_pkg::IDX_W-1:0]    br;
  logic [bmp3_pkg::TRIPLE_W-1:0] tri_old;
  logic [bmp3_pkg::TRIPLE_W-1:0] triple_n;
  logic in_blk, emit, accept;

  // Sizes are clamped once, when written
  assign cfg_wx = LXW'(cfg_data_i);
  assign cfg_hx = LYW'(cfg_data_i);

  always_comb begin
    if (cfg_wx < LXW'(bmp3_pkg::MIN_SIZE)) begin
      width_clamped = XW'(bmp3_pkg::MIN_SIZE);
    end else if (cfg_wx > LXW'(MAX_WIDTH)) begin
      width_clamped = XW'(MAX_WIDTH);
    end else begin
      width_clamped = cfg_wx[XW-1:0];
    end
    if (cfg_hx < LYW'(bmp3_pkg::MIN_SIZE)) begin
      height_clamped = YW'(bmp3_pkg::MIN_SIZE);
    end else if (cfg_hx > LYW'(MAX_HEIGHT)) begin
      height_clamped = YW'(MAX_HEIGHT);
    end else begin
      height_clamped = cfg_hx[YW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= XW'(W_RST);
      height_q <= YW'(H_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmp3_pkg::REG_IMAGE_WIDTH:  width_q  <= width_clamped;
        bmp3_pkg::REG_IMAGE_HEIGHT: height_q <= height_clamped;
        default: ;
      endcase
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = push_ready_i;

  always_comb begin
    base    = sof_i ? '0 : XW'(base_q);
    cx      = sof_i ? bmp3_pkg::BLK_FIRST : cx_q;
    bc      = sof_i ? '0 : bc_q;
    rbase   = sof_i ? '0 : YW'(rbase_q);
    ry      = sof_i ? bmp3_pkg::BLK_FIRST : ry_q;
    br      = sof_i ? '0 : br_q;
    tri_old = sof_i ? '0 : triple_q;

    // Wrap a position left stale by a smaller size
    if ((base + XW'(cx)) >= width_q) begin
      base = '0;
      cx   = bmp3_pkg::BLK_FIRST;
      bc   = '0;
      if (ry == bmp3_pkg::BLK_LAST) begin
        ry    = bmp3_pkg::BLK_FIRST;
        rbase = rbase + YW'(bmp3_pkg::BLOCK);
        br    = br + bmp3_pkg::IDX_W'(1);
      end else begin
        ry = ry + 2'd1;
      end
    end
    if ((rbase + YW'(ry)) >= height_q) begin
      rbase = '0;
      ry    = bmp3_pkg::BLK_FIRST;
      br    = '0;
    end

    in_blk = ((base + XW'(bmp3_pkg::BLOCK)) <= width_q) &&
             ((rbase + YW'(bmp3_pkg::BLOCK)) <= height_q);
    item_last_o = ((base + XW'(2 * bmp3_pkg::BLOCK)) > width_q) &&
                  ((rbase + YW'(2 * bmp3_pkg::BLOCK)) > height_q);
    item_bc_o = bc;
    item_br_o = br;
    item_ry_o = ry;

    triple_n = (cx == bmp3_pkg::BLK_FIRST) ? bmp3_pkg::TRIPLE_W'(pixel_i)
                                           : tri_old + bmp3_pkg::TRIPLE_W'(pixel_i);
    item_triple_o = triple_n;
    emit = in_blk && (cx == bmp3_pkg::BLK_LAST);

    // Advance to the next pixel
    if (cx == bmp3_pkg::BLK_LAST) begin
      cx   = bmp3_pkg::BLK_FIRST;
      base = base + XW'(bmp3_pkg::BLOCK);
      bc   = bc + AW'(1);
    end else begin
      cx = cx + 2'd1;
    end
    if ((base + XW'(cx)) >= width_q) begin
      base = '0;
      cx   = bmp3_pkg::BLK_FIRST;
      bc   = '0;
      if (ry == bmp3_pkg::BLK_LAST) begin
        ry    = bmp3_pkg::BLK_FIRST;
        rbase = rbase + YW'(bmp3_pkg::BLOCK);
        br    = br + bmp3_pkg::IDX_W'(1);
      end else begin
        ry = ry + 2'd1;
      end
      if ((rbase + YW'(ry)) >= height_q) begin
        rbase = '0;
        ry    = bmp3_pkg::BLK_FIRST;
        br    = '0;
      end
    end
  end

  assign push_valid_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      cx_q     <= bmp3_pkg::BLK_FIRST;
      bc_q     <= '0;
      rbase_q  <= '0;
      ry_q     <= bmp3_pkg::BLK_FIRST;
      br_q     <= '0;
      triple_q <= '0;
    end else if (accept) begin
      base_q   <= base[CW-1:0];
      cx_q     <= cx;
      bc_q     <= bc;
      rbase_q  <= rbase[RW-1:0];
      ry_q     <= ry;
      br_q     <= br;
      triple_q <= in_blk ? triple_n : tri_old;
    end
  end

endmodule

// File: hdl/bmp3_back.sv
module bmp3_back #(
  parameter int MAX_WIDTH = bmp3_pkg::MAX_WIDTH_DEF,
  localparam int BLK_DEPTH = MAX_WIDTH / bmp3_pkg::BLOCK,
  localparam int AW = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  logic [bmp3_pkg::TRIPLE_W-1:0]   q_triple_i,
  input  logic [AW-1:0]                   q_bc_i,
  input  logic [bmp3_pkg::IDX_W-1:0]      q_br_i,
  input  logic [1:0]                      q_ry_i,
  input  logic                            q_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bmp3_pkg::MEAN_W-1:0]     mean_o,
  output logic [bmp3_pkg::IDX_W-1:0]      row_o,
  output logic [bmp3_pkg::IDX_W-1:0]      col_o,
  output logic                            last_o
);

  // Stage 1: block sum read pending
  logic                          s1_v_q;
  logic [bmp3_pkg::TRIPLE_W-1:0] s1_triple_q;
  logic [AW-1:0]                 s1_bc_q;
  logic [bmp3_pkg::IDX_W-1:0]    s1_br_q;
  logic [1:0]                    s1_ry_q;
  logic                          s1_last_q;

  // Last write to the sum memory
  logic                       fwd_v_q;
  logic [AW-1:0]              fwd_addr_q;
  logic [bmp3_pkg::SUM_W-1:0] fwd_data_q;

  // Stage 2: finished nine-pixel sum
  logic                       s2_v_q;
  logic [bmp3_pkg::SUM_W-1:0] s2_sum_q;
  logic [bmp3_pkg::IDX_W-1:0] s2_br_q;
  logic [bmp3_pkg::IDX_W-1:0] s2_bc_q;
  logic                       s2_last_q;

  logic                        out_v_q;
  logic [bmp3_pkg::MEAN_W-1:0] mean_q;
  logic [bmp3_pkg::IDX_W-1:0]  row_q, col_q;
  logic                        last_q;

  logic [bmp3_pkg::SUM_W-1:0]  rd_data, old_sum, blk_sum;
  logic [bmp3_pkg::PROD_W-1:0] prod;
  logic pop, s1_rdy, s1_go, s1_emit, s2_rdy, out_rdy;

  assign out_rdy = !out_v_q || out_ready_i;
  assign s2_rdy  = !s2_v_q || out_rdy;
  assign s1_emit = (s1_ry_q == bmp3_pkg::BLK_LAST);
  assign s1_go   = s1_v_q && (!s1_emit || s2_rdy);
  assign s1_rdy  = !s1_v_q || s1_go;
  assign pop     = q_valid_i && s1_rdy;
  assign q_ready_o = s1_rdy;

  bmp3_ram #(
    .WIDTH (bmp3_pkg::SUM_W),
    .DEPTH (BLK_DEPTH)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_bc_q),
    .wdata_i (blk_sum),
    .re_i    (pop),
    .raddr_i (q_bc_i),
    .rdata_o (rd_data)
  );

  // Bypass the memory when the previous word wrote the same block column
  assign old_sum = (fwd_v_q && (fwd_addr_q == s1_bc_q)) ? fwd_data_q : rd_data;
  assign blk_sum = (s1_ry_q == bmp3_pkg::BLK_FIRST) ? bmp3_pkg::SUM_W'(s1_triple_q)
                 : old_sum + bmp3_pkg::SUM_W'(s1_triple_q);

  assign prod = bmp3_pkg::PROD_W'(s2_sum_q) * bmp3_pkg::PROD_W'(bmp3_pkg::DIV9_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= pop;
      end
      if (s1_go) begin
        fwd_v_q <= 1'b1;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_go && s1_emit;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_triple_q <= q_triple_i;
      s1_bc_q     <= q_bc_i;
      s1_br_q     <= q_br_i;
      s1_ry_q     <= q_ry_i;
      s1_last_q   <= q_last_i;
    end
    if (s1_go) begin
      fwd_addr_q <= s1_bc_q;
      fwd_data_q <= blk_sum;
    end
    if (s2_rdy) begin
      s2_sum_q  <= blk_sum;
      s2_br_q   <= s1_br_q;
      s2_bc_q   <= bmp3_pkg::IDX_W'(s1_bc_q);
      s2_last_q <= s1_last_q;
    end
    if (out_rdy) begin
      mean_q <= prod[bmp3_pkg::DIV9_SHIFT +: bmp3_pkg::MEAN_W];
      row_q  <= s2_br_q;
      col_q  <= s2_bc_q;
      last_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign mean_o      = mean_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign last_o      = last_q;

endmodule

// File: hdl/block_mean_pixelate_3x3.sv
// 3x3 block-mean pixelation for 8-bit grayscale video in raster order. One pixel
// is taken per clock while the queue has room; the front end tracks the pixel
// position and sums each group of three pixels of a block row, and hands one
// word per group through a four-entry queue to the back end, which adds it into
// a per-column block sum kept in a single read/write RAM of MAX_WIDTH/3 entries
// (one read and one write per group, with a bypass for back-to-back words on one
// column). A block mean passes the queue, stages 1 and 2 and the output register
// and is then valid with row and column of the block; the mean is sum/9 by
// reciprocal multiply. The input stalls only while the queue is full.
// Sizes are clamped to 3..MAX on write, and partial blocks at the right and
// bottom edges produce nothing. The block-sum RAM needs no clearing pass: each
// entry is written by the top row of its band before it is read.
module block_mean_pixelate_3x3 #(
  parameter int MAX_WIDTH  = bmp3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmp3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bmp3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bmp3_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bmp3_pkg::PIX_W-1:0]         s_axis_tdata,  // pixel[7:0]
  input  logic                               s_axis_tuser,  // start_of_frame
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bmp3_pkg::TDATA_W-1:0]       m_axis_tdata,  // block_mean[7:0],
                                                            // block_row[17:8],
                                                            // block_col[27:18]
  output logic                               m_axis_tlast   // last_block
);

  localparam int BLK_DEPTH = MAX_WIDTH / bmp3_pkg::BLOCK;
  localparam int AW = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int QW = bmp3_pkg::TRIPLE_W + AW + bmp3_pkg::IDX_W + 2 + 1;
  localparam int PAD_W = bmp3_pkg::TDATA_W - bmp3_pkg::MEAN_W - 2 * bmp3_pkg::IDX_W;

  logic                          push_valid, push_ready;
  logic [bmp3_pkg::TRIPLE_W-1:0] f_triple, b_triple;
  logic [AW-1:0]                 f_bc, b_bc;
  logic [bmp3_pkg::IDX_W-1:0]    f_br, b_br;
  logic [1:0]                    f_ry, b_ry;
  logic                          f_last, b_last;
  logic [QW-1:0]                 q_in, q_out;
  logic                          q_valid, q_ready;
  logic [bmp3_pkg::MEAN_W-1:0]   mean;
  logic [bmp3_pkg::IDX_W-1:0]    row, col;

  bmp3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .pixel_i       (s_axis_tdata),
    .sof_i         (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .item_triple_o (f_triple),
    .item_bc_o     (f_bc),
    .item_br_o     (f_br),
    .item_ry_o     (f_ry),
    .item_last_o   (f_last)
  );

  assign q_in = {f_last, f_ry, f_br, f_bc, f_triple};

  bmp3_fifo #(
    .WIDTH (QW),
    .DEPTH (bmp3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_data_i   (q_in),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_out)
  );

  assign {b_last, b_ry, b_br, b_bc, b_triple} = q_out;

  bmp3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_triple_i  (b_triple),
    .q_bc_i      (b_bc),
    .q_br_i      (b_br),
    .q_ry_i      (b_ry),
    .q_last_i    (b_last),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mean_o      (mean),
    .row_o       (row),
    .col_o       (col),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, col, row, mean};

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("group word pushed into a full queue");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output word present right after reset");

  a_input_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready) |-> (q_valid && !push_ready))
    else $error("input stalled while the queue has room");

endmodule
